// ----- rtl/uart_dual_ring_fifo_unit_assert.svh -----
// Assertion macros for the dual UART ring FIFO unit
`ifndef UART_DUAL_RING_FIFO_UNIT_ASSERT_SVH
`define UART_DUAL_RING_FIFO_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define UDRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define UDRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/udrf_pkg.sv -----
// Shared types and codes of the dual UART ring FIFO unit
package udrf_pkg;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    OP_RX_STORE = 3'd0,
    OP_RX_READ  = 3'd1,
    OP_RX_FLUSH = 3'd2,
    OP_TX_WRITE = 3'd3,
    OP_TX_DRAIN = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Source of the result byte
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_RX   = 2'd1,
    SRC_TX   = 2'd2
  } src_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_LOAD = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [5:0] rx_level;
    logic       tx_irq_on;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/udrf_ram.sv -----
// Generic single write port RAM with registered read
module udrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read one entry each per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/udrf_ctrl.sv -----
// Controller state machine of the dual UART ring FIFO unit
module udrf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  udrf_pkg::sts_t  sts_i,
  output udrf_pkg::cmd_t  cmd_o
);

  udrf_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= udrf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence accept, then result load once the output register frees up
  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      udrf_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = udrf_pkg::S_LOAD;
        end
      end
      udrf_pkg::S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = udrf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = udrf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/udrf_dp.sv -----
// Datapath: ring pointers, byte memories, interrupt flag and output register
module udrf_dp #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  udrf_pkg::cmd_t      cmd_i,
  output udrf_pkg::sts_t      sts_o,
  input  udrf_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output udrf_pkg::out_item_t out_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = PW + 1;
  localparam logic [PW-1:0] LastPos = PW'(DEPTH - 1);

  logic [PW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [PW-1:0] rx_head_nxt, rx_tail_nxt, tx_head_nxt, tx_tail_nxt;
  logic          flag_q, flag_d;
  udrf_pkg::src_e    src_q, src_d;
  udrf_pkg::status_e status_q, status_d;
  logic          rx_we, rx_re, tx_we, tx_re;
  logic [7:0]    rx_rdata, tx_rdata;
  logic [CW-1:0] rx_cnt;
  logic          out_valid_q;
  udrf_pkg::out_item_t out_item_q, out_item_d;

  // Advance pointers with wrap at the last position
  assign rx_head_nxt = (rx_head_q == LastPos) ? '0 : rx_head_q + 1'b1;
  assign rx_tail_nxt = (rx_tail_q == LastPos) ? '0 : rx_tail_q + 1'b1;
  assign tx_head_nxt = (tx_head_q == LastPos) ? '0 : tx_head_q + 1'b1;
  assign tx_tail_nxt = (tx_tail_q == LastPos) ? '0 : tx_tail_q + 1'b1;

  // Decode the accepted operation
  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    flag_d    = flag_q;
    src_d     = src_q;
    status_d  = status_q;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    if (cmd_i.accept) begin
      src_d    = udrf_pkg::SRC_NONE;
      status_d = udrf_pkg::STAT_OK;
      unique case (in_item_i.operation)
        udrf_pkg::OP_RX_STORE: begin
          if (rx_head_nxt == rx_tail_q) begin
            status_d = udrf_pkg::STAT_FULL;
          end else begin
            rx_we     = 1'b1;
            rx_head_d = rx_head_nxt;
          end
        end
        udrf_pkg::OP_RX_READ: begin
          if (rx_head_q == rx_tail_q) begin
            status_d = udrf_pkg::STAT_EMPTY;
          end else begin
            rx_re     = 1'b1;
            src_d     = udrf_pkg::SRC_RX;
            rx_tail_d = rx_tail_nxt;
          end
        end
        udrf_pkg::OP_RX_FLUSH: begin
          rx_tail_d = rx_head_q;
        end
        udrf_pkg::OP_TX_WRITE: begin
          if (tx_head_nxt == tx_tail_q) begin
            status_d = udrf_pkg::STAT_FULL;
          end else begin
            tx_we     = 1'b1;
            tx_head_d = tx_head_nxt;
            flag_d    = 1'b1;
          end
        end
        udrf_pkg::OP_TX_DRAIN: begin
          if (tx_head_q == tx_tail_q) begin
            status_d = udrf_pkg::STAT_EMPTY;
            flag_d   = 1'b0;
          end else begin
            tx_re     = 1'b1;
            src_d     = udrf_pkg::SRC_TX;
            tx_tail_d = tx_tail_nxt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold pointers and the interrupt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      flag_q    <= 1'b0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      flag_q    <= flag_d;
    end
  end

  // Hold the pending result source and status
  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    status_q <= status_d;
  end

  udrf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_head_q),
    .wdata_i(in_item_i.data_byte),
    .re_i   (rx_re),
    .raddr_i(rx_tail_q),
    .rdata_o(rx_rdata)
  );

  udrf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_head_q),
    .wdata_i(in_item_i.data_byte),
    .re_i   (tx_re),
    .raddr_i(tx_tail_q),
    .rdata_o(tx_rdata)
  );

  // Receive fill level, head minus tail modulo the ring size
  always_comb begin
    if (rx_head_q >= rx_tail_q) begin
      rx_cnt = CW'(rx_head_q) - CW'(rx_tail_q);
    end else begin
      rx_cnt = CW'(rx_head_q) + CW'(DEPTH) - CW'(rx_tail_q);
    end
  end

  // Assemble the result item
  always_comb begin
    case (src_q)
      udrf_pkg::SRC_RX: out_item_d.data_out = rx_rdata;
      udrf_pkg::SRC_TX: out_item_d.data_out = tx_rdata;
      default:          out_item_d.data_out = 8'd0;
    endcase
    out_item_d.status    = status_q;
    out_item_d.rx_level  = 6'(rx_cnt);
    out_item_d.tx_irq_on = flag_q;
  end

  // Output register: set on load, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_item_q <= out_item_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_item_q;

endmodule

// ----- rtl/uart_dual_ring_fifo_unit.sv -----
// Top level of the dual UART ring FIFO unit
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid_i/in_stall_o   | in_item_i  (operation, data_byte)
//  out     | out_valid_o/out_stall_i | out_item_o (data_out, status,
//          |                      |             rx_level, tx_irq_on)
//
// For each item, the accept cycle updates the pointers and starts the
// registered memory read; the output register then loads once it is free.
// One item is in flight at a time; a result waiting in the output register
// does not block the next accept, only that item's load.
// Reset clears the pointers and the interrupt flag; the byte memories keep
// their contents and need no clearing pass.
// A stalled output holds its item until taken.
`include "uart_dual_ring_fifo_unit_assert.svh"

module uart_dual_ring_fifo_unit #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  udrf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output udrf_pkg::out_item_t out_item_o
);

  udrf_pkg::cmd_t cmd;
  udrf_pkg::sts_t sts;

  udrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  udrf_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

  // Busy in the cycle after an accepted item
  `UDRF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by busy")

  // A load never overwrites a result that is still waiting
  `UDRF_ASSERT(a_load_no_overwrite, !cmd.load || !out_valid_o || !out_stall_i, "result overwritten")

  // A taken result is not shown again without a new load
  `UDRF_ASSERT_NEXT(a_no_repeat, out_valid_o && !out_stall_i && !cmd.load, !out_valid_o, "result repeated")

endmodule

// ----- tb/tb_uart_dual_ring_fifo_unit.sv -----
// Self-checking testbench for the dual UART ring FIFO unit with random idling on both channels
module tb_uart_dual_ring_fifo_unit;
  import udrf_pkg::*;

  localparam int          DEPTH        = 64;
  localparam int          RANDOM_ITEMS = 1700;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 8;
  // Operation codes the unit does not decode
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

  // Traffic shapes of the random part
  typedef enum int {
    MODE_FILL_RX,
    MODE_EMPTY_RX,
    MODE_FILL_TX,
    MODE_EMPTY_TX,
    MODE_MIXED
  } traffic_mode_e;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_stall;
  in_item_t  in_item    = '0;
  logic      out_valid;
  logic      out_stall  = 1'b0;
  out_item_t out_item;

  // Items still to send and results still owed by the unit
  in_item_t    ops_to_send[$];
  out_item_t   fifo_results_due[$];

  // Shadow copy of both rings
  logic [7:0]  rx_ring [DEPTH];
  logic [7:0]  tx_ring [DEPTH];
  int unsigned rx_wr_ptr, rx_rd_ptr, tx_wr_ptr, tx_rd_ptr;
  logic        tx_irq_shadow;

  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned full_count   = 0;
  int unsigned empty_count  = 0;
  int unsigned gap_left     = 0;
  int unsigned in_quiet     = 0;
  int unsigned stall_left   = 0;
  int unsigned out_quiet    = 0;

  uart_dual_ring_fifo_unit #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #10 clk_i = ~clk_i;

  // Apply one operation to the shadow rings and return the result it yields
  function automatic out_item_t predict_fifo_result(in_item_t it);
    out_item_t   res;
    int unsigned nxt;
    res = '0;
    res.status = STAT_OK;
    case (op_e'(it.operation))
      OP_RX_STORE: begin
        nxt = (rx_wr_ptr + 1) % DEPTH;
        if (nxt == rx_rd_ptr) begin
          res.status = STAT_FULL;
        end else begin
          rx_ring[rx_wr_ptr] = it.data_byte;
          rx_wr_ptr = nxt;
        end
      end
      OP_RX_READ: begin
        if (rx_wr_ptr == rx_rd_ptr) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data_out = rx_ring[rx_rd_ptr];
          rx_rd_ptr = (rx_rd_ptr + 1) % DEPTH;
        end
      end
      OP_RX_FLUSH: begin
        rx_rd_ptr = rx_wr_ptr;
      end
      OP_TX_WRITE: begin
        nxt = (tx_wr_ptr + 1) % DEPTH;
        if (nxt == tx_rd_ptr) begin
          res.status = STAT_FULL;
        end else begin
          tx_ring[tx_wr_ptr] = it.data_byte;
          tx_wr_ptr = nxt;
          tx_irq_shadow = 1'b1;
        end
      end
      OP_TX_DRAIN: begin
        if (tx_wr_ptr == tx_rd_ptr) begin
          tx_irq_shadow = 1'b0;
          res.status = STAT_EMPTY;
        end else begin
          res.data_out = tx_ring[tx_rd_ptr];
          tx_rd_ptr = (tx_rd_ptr + 1) % DEPTH;
        end
      end
      default: begin
      end
    endcase
    res.rx_level  = 6'((rx_wr_ptr + DEPTH - rx_rd_ptr) % DEPTH);
    res.tx_irq_on = tx_irq_shadow;
    if (res.status == STAT_FULL) full_count++;
    if (res.status == STAT_EMPTY) empty_count++;
    return res;
  endfunction

  // Draw the idle cycles before the next item, with occasional runs of none
  function automatic int unsigned draw_pause(inout int unsigned quiet_run);
    int unsigned pause;
    if (quiet_run > 0) begin
      quiet_run--;
      pause = 0;
    end else begin
      pause = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) quiet_run = $urandom_range(8, 32);
    end
    return pause;
  endfunction

  // Pick an operation weighted by the current traffic shape
  function automatic logic [2:0] pick_op(traffic_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (roll < 4) return OP_RX_FLUSH;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL_RX:  return (roll < 75) ? OP_RX_STORE : (roll < 85) ? OP_RX_READ :
                            (roll < 93) ? OP_TX_WRITE : OP_TX_DRAIN;
      MODE_EMPTY_RX: return (roll < 70) ? OP_RX_READ : (roll < 80) ? OP_RX_STORE :
                            (roll < 90) ? OP_TX_DRAIN : OP_TX_WRITE;
      MODE_FILL_TX:  return (roll < 75) ? OP_TX_WRITE : (roll < 85) ? OP_TX_DRAIN :
                            (roll < 93) ? OP_RX_STORE : OP_RX_READ;
      MODE_EMPTY_TX: return (roll < 70) ? OP_TX_DRAIN : (roll < 80) ? OP_TX_WRITE :
                            (roll < 90) ? OP_RX_READ : OP_RX_STORE;
      default:       return (roll < 25) ? OP_RX_STORE : (roll < 50) ? OP_RX_READ :
                            (roll < 75) ? OP_TX_WRITE : OP_TX_DRAIN;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] op, logic [7:0] data);
    in_item_t it;
    it.operation = op;
    it.data_byte = data;
    ops_to_send.push_back(it);
  endtask

  // Driver: present queued items, hold them while stalled, predict on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fifo_results_due.push_back(predict_fifo_result(in_item));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          in_item  <= ops_to_send.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_pause(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results, compare against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    out_item_t want;
    int unsigned hold;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (fifo_results_due.size() == 0) begin
          $display("%0t: result with nothing pending: data_out=%02h status=%0d rx_level=%0d irq=%0b",
                   $time, out_item.data_out, out_item.status, out_item.rx_level,
                   out_item.tx_irq_on);
          error_count++;
        end else begin
          want = fifo_results_due.pop_front();
          if (out_item.data_out !== want.data_out) begin
            $display("%0t: data_out mismatch: expected %02h, actual %02h",
                     $time, want.data_out, out_item.data_out);
            error_count++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_item.status);
            error_count++;
          end
          if (out_item.rx_level !== want.rx_level) begin
            $display("%0t: rx_level mismatch: expected %0d, actual %0d",
                     $time, want.rx_level, out_item.rx_level);
            error_count++;
          end
          if (out_item.tx_irq_on !== want.tx_irq_on) begin
            $display("%0t: tx_irq_on mismatch: expected %0b, actual %0b",
                     $time, want.tx_irq_on, out_item.tx_irq_on);
            error_count++;
          end
        end
        hold = draw_pause(out_quiet);
        stall_left = hold;
        out_stall <= (hold != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, fifo_results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    traffic_mode_e mode;
    int unsigned   phase_len;

    for (int i = 0; i < DEPTH; i++) begin
      rx_ring[i] = '0;
      tx_ring[i] = '0;
    end
    rx_wr_ptr = 0;
    rx_rd_ptr = 0;
    tx_wr_ptr = 0;
    tx_rd_ptr = 0;
    tx_irq_shadow = 1'b0;

    // Directed: empty reads, byte extremes, flush, interrupt set and clear, unused codes
    queue_op(OP_RX_READ,  8'h00);
    queue_op(OP_TX_DRAIN, 8'hFF);
    queue_op(OP_RX_STORE, 8'h00);
    queue_op(OP_RX_STORE, 8'hFF);
    queue_op(OP_RX_READ,  8'hFF);
    queue_op(OP_RX_READ,  8'h00);
    queue_op(OP_RX_READ,  8'h00);
    queue_op(OP_RX_STORE, 8'hA5);
    queue_op(OP_RX_STORE, 8'h5A);
    queue_op(OP_RX_FLUSH, 8'hFF);
    queue_op(OP_RX_READ,  8'h00);
    queue_op(OP_TX_WRITE, 8'hFF);
    queue_op(OP_TX_WRITE, 8'h00);
    queue_op(OP_TX_DRAIN, 8'h00);
    queue_op(OP_TX_DRAIN, 8'h00);
    queue_op(OP_TX_DRAIN, 8'h00);
    queue_op(OP_RX_FLUSH, 8'h00);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) queue_op(3'(op), 8'hFF);

    // Random: phases of biased traffic; fill phases run long enough to hit a full ring
    while (ops_to_send.size() < RANDOM_ITEMS + 20) begin
      mode = traffic_mode_e'($urandom_range(MODE_FILL_RX, MODE_MIXED));
      phase_len = (mode == MODE_FILL_RX || mode == MODE_FILL_TX) ?
                  $urandom_range(90, 150) : $urandom_range(30, 100);
      repeat (phase_len) queue_op(pick_op(mode), 8'($urandom_range(0, 255)));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid || fifo_results_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results in %0d cycles", items_sent,
             results_seen, cycle_count);
    $display("Results on a full ring: %0d, on an empty ring: %0d", full_count, empty_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/udrf_pkg.sv
rtl/udrf_ram.sv
rtl/udrf_ctrl.sv
rtl/udrf_dp.sv
rtl/uart_dual_ring_fifo_unit.sv
tb/tb_uart_dual_ring_fifo_unit.sv
